[src/reader_frame_deframer_unit_assert.svh]
// Assertion macros for the reader frame deframer checker.
// Used by rfd_checker; needs clk_i and rst_ni in scope.
`ifndef READER_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define READER_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rfd_pkg.sv]
// Shared types and constants of the reader frame deframer.
// No dependencies.
package rfd_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int HDR_BYTES       = 8;
  localparam int CHK_BYTES       = 2;
  localparam int SW_HI_POS       = 4;
  localparam int SW_LO_POS       = 5;
  localparam int LEN_HI_POS      = 6;
  localparam int LEN_LO_POS      = 7;
  localparam logic [7:0] SYNC_RESET = 8'd178;

  typedef enum logic [1:0] {
    FS_GOOD     = 2'd0,
    FS_CHK_ERR  = 2'd1,
    FS_TOO_LONG = 2'd2
  } frame_status_e;

  typedef enum logic [1:0] {
    ST_RX,
    ST_RD,
    ST_OUT
  } rfd_state_e;

  typedef struct packed {
    logic en;
    logic first;
  } sum_ctl_t;

endpackage

[src/reader_frame_deframer_unit.sv]
// Receive: one byte per cycle unless in_stall_o is high; errors and empty frames show
// in the cycle after the last byte. A good frame of n payload bytes then streams them
// out, each byte by a store read and then an output load; input stalls meanwhile.
// Bytes 7 and the last check byte also wait while an earlier result is stalled in output.
// Reset (async, low): hunting for sync, sync byte 178, output empty; store left as is.
module reader_frame_deframer_unit import rfd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sync_byte_we_i,
  input  logic [7:0]  sync_byte_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_status_o,
  output logic [15:0] status_word_o,
  output logic [5:0]  payload_len_o,
  output logic        has_byte_o,
  output logic [7:0]  payload_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o
);

  localparam int MAX_LEN = FRAME_BYTES - HDR_BYTES - CHK_BYTES;
  localparam int AW      = $clog2(MAX_LEN);
  localparam int CW      = ($clog2(FRAME_BYTES) > 6) ? $clog2(FRAME_BYTES) : 6;

  rfd_state_e    state_q, state_d;
  logic [7:0]    sync_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_q, len_d;
  logic [7:0]    len_hi_q, len_hi_d;
  logic [15:0]   sw_q, sw_d;
  logic [7:0]    chk_hi_q, chk_hi_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;

  logic          out_valid_q, out_valid_d;
  frame_status_e st_q, st_d;
  logic [5:0]    plen_q, plen_d;
  logic          has_q, has_d;
  logic [7:0]    pb_q, pb_d;
  logic [5:0]    idx_q, idx_d;
  logic          last_q, last_d;
  logic [15:0]   osw_q, osw_d;

  logic          acc, hunt, is_hdr, pay, chk_pos, fin, at_len, too_long, out_free;
  logic [CW-1:0] end_pay;
  logic [15:0]   len_full;
  logic          chk_ok, rd_last;
  sum_ctl_t      sum_ctl;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data;

  assign out_free = !out_valid_q || !out_stall_i;
  assign hunt     = (cnt_q == '0);
  assign is_hdr   = (cnt_q < CW'(HDR_BYTES));
  assign end_pay  = CW'(HDR_BYTES) + len_q;
  assign pay      = !is_hdr && (cnt_q < end_pay);
  assign chk_pos  = !is_hdr && (cnt_q == end_pay);
  assign fin      = !is_hdr && (cnt_q == end_pay + CW'(1));
  assign at_len   = (cnt_q == CW'(LEN_LO_POS));
  assign len_full = {len_hi_q, rx_byte_i};
  assign too_long = (len_full > 16'(MAX_LEN));
  assign rd_last  = (CW'(rd_idx_q) + CW'(1) == len_q);

  assign in_stall_o = (state_q != ST_RX) || ((at_len || fin) && !out_free);
  assign acc        = in_valid_i && !in_stall_o;

  assign sum_ctl.first = hunt;
  assign sum_ctl.en    = acc && (is_hdr || pay) && (!hunt || (rx_byte_i == sync_q));
  assign wr_en         = acc && pay;
  assign wr_addr       = AW'(cnt_q - CW'(HDR_BYTES));
  assign rd_en         = (state_q == ST_RD);

  rfd_sum u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sum_ctl),
    .byte_i     (rx_byte_i),
    .chk_word_i ({chk_hi_q, rx_byte_i}),
    .chk_ok_o   (chk_ok)
  );

  rfd_store #(.DEPTH(MAX_LEN)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (rx_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    len_hi_d    = len_hi_q;
    sw_d        = sw_q;
    chk_hi_d    = chk_hi_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    st_d        = st_q;
    plen_d      = plen_q;
    has_d       = has_q;
    pb_d        = pb_q;
    idx_d       = idx_q;
    last_d      = last_q;
    osw_d       = osw_q;
    unique case (state_q)
      ST_RX: begin
        if (acc) begin
          if (hunt) begin
            if (rx_byte_i == sync_q) begin
              cnt_d = CW'(1);
            end
          end else begin
            cnt_d = cnt_q + CW'(1);
            if (cnt_q == CW'(SW_HI_POS)) sw_d[15:8] = rx_byte_i;
            if (cnt_q == CW'(SW_LO_POS)) sw_d[7:0] = rx_byte_i;
            if (cnt_q == CW'(LEN_HI_POS)) len_hi_d = rx_byte_i;
            if (chk_pos) chk_hi_d = rx_byte_i;
            if (at_len) begin
              len_d = CW'(len_full);
              if (too_long) begin
                cnt_d       = '0;
                out_valid_d = 1'b1;
                st_d        = FS_TOO_LONG;
                osw_d       = sw_q;
                plen_d      = '0;
                has_d       = 1'b0;
                pb_d        = '0;
                idx_d       = '0;
                last_d      = 1'b1;
              end
            end
            if (fin) begin
              cnt_d = '0;
              if (!chk_ok || len_q == '0) begin
                out_valid_d = 1'b1;
                st_d        = chk_ok ? FS_GOOD : FS_CHK_ERR;
                osw_d       = sw_q;
                plen_d      = 6'(len_q);
                has_d       = 1'b0;
                pb_d        = '0;
                idx_d       = '0;
                last_d      = 1'b1;
              end else begin
                rd_idx_d = '0;
                state_d  = ST_RD;
              end
            end
          end
        end
      end
      ST_RD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          st_d        = FS_GOOD;
          osw_d       = sw_q;
          plen_d      = 6'(len_q);
          has_d       = 1'b1;
          pb_d        = rd_data;
          idx_d       = 6'(rd_idx_q);
          last_d      = rd_last;
          if (rd_last) begin
            state_d = ST_RX;
          end else begin
            rd_idx_d = rd_idx_q + AW'(1);
            state_d  = ST_RD;
          end
        end
      end
      default: state_d = ST_RX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RX;
      sync_q      <= SYNC_RESET;
      cnt_q       <= '0;
      len_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (sync_byte_we_i) sync_q <= sync_byte_i;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_hi_q <= len_hi_d;
    sw_q     <= sw_d;
    chk_hi_q <= chk_hi_d;
    st_q     <= st_d;
    osw_q    <= osw_d;
    plen_q   <= plen_d;
    has_q    <= has_d;
    pb_q     <= pb_d;
    idx_q    <= idx_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = st_q;
  assign status_word_o  = osw_q;
  assign payload_len_o  = plen_q;
  assign has_byte_o     = has_q;
  assign payload_byte_o = pb_q;
  assign byte_index_o   = idx_q;
  assign last_o         = last_q;

endmodule

[src/rfd_sum.sv]
// Checksum unit: one 16-bit adder that accumulates frame bytes, plus the check compare.
// Depends on rfd_pkg.
module rfd_sum import rfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sum_ctl_t    ctl_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] chk_word_i,
  output logic        chk_ok_o
);

  logic [15:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.en) begin
      sum_d = (ctl_i.first ? 16'd0 : sum_q) + {8'd0, byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= 16'd0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign chk_ok_o = (chk_word_i == ~sum_q);

endmodule

[src/rfd_store.sv]
// Payload store: one write port, one registered read port.
// Depends on rfd_pkg.
module rfd_store import rfd_pkg::*; #(
  parameter int DEPTH = FRAME_BYTES_DEF - HDR_BYTES - CHK_BYTES,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/rfd_checker.sv]
// Port-level checks of the reader frame deframer, bound to the top level.
// Depends on rfd_pkg and reader_frame_deframer_unit_assert.svh.
`include "reader_frame_deframer_unit_assert.svh"

module rfd_checker import rfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  frame_status_o,
  input logic [5:0]  payload_len_o,
  input logic        has_byte_o,
  input logic [7:0]  payload_byte_o,
  input logic [5:0]  byte_index_o,
  input logic        last_o
);

  `RFD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(payload_byte_o) && $stable(last_o) && $stable(byte_index_o), "stalled request changed")
  `RFD_ASSERT_NOW(a_err_single, out_valid_o && frame_status_o != FS_GOOD, !has_byte_o && last_o && byte_index_o == 6'd0, "error request not a single last result")
  `RFD_ASSERT_NOW(a_long_len, out_valid_o && frame_status_o == FS_TOO_LONG, payload_len_o == 6'd0 && payload_byte_o == 8'd0, "too-long request carries length")
  `RFD_ASSERT_NOW(a_nobyte_last, out_valid_o && !has_byte_o, last_o && payload_byte_o == 8'd0, "request without byte not last")

endmodule

bind reader_frame_deframer_unit rfd_checker u_rfd_checker (.*);

[tb/reader_frame_deframer_unit_tb.sv]
// Self-checking testbench for reader_frame_deframer_unit: directed frames, then random
// frames, noise and cut frames under several sync bytes, with random request gaps and stalls.
// Depends on rfd_pkg and the reader_frame_deframer_unit RTL.
`timescale 1ns / 100ps

module reader_frame_deframer_unit_tb;
  import rfd_pkg::*;

  localparam int FRAME_BYTES = FRAME_BYTES_DEF;
  localparam int DIR_ROWS    = 30;
  localparam int PHASE_BYTES = 36;
  localparam int LIMIT_NS    = 2_000_000;

  typedef struct packed {
    frame_status_e fstat;
    logic [15:0]   sword;
    logic [5:0]    plen;
    logic          has;
    logic [7:0]    pbyte;
    logic [5:0]    bidx;
    logic          last;
  } frame_res_t;

  typedef struct packed {
    logic [7:0]    b;
    logic          typed;
    frame_status_e fstat;
    logic [15:0]   sword;
  } dir_row_t;

  typedef enum {FK_GOOD, FK_BAD_CHK, FK_TOO_LONG, FK_CUT} frame_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        sync_byte_we_i;
  logic [7:0]  sync_byte_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  frame_status_o;
  logic [15:0] status_word_o;
  logic [5:0]  payload_len_o;
  logic        has_byte_o;
  logic [7:0]  payload_byte_o;
  logic [5:0]  byte_index_o;
  logic        last_o;

  reader_frame_deframer_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sync_byte_we_i(sync_byte_we_i),
    .sync_byte_i   (sync_byte_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_status_o(frame_status_o),
    .status_word_o (status_word_o),
    .payload_len_o (payload_len_o),
    .has_byte_o    (has_byte_o),
    .payload_byte_o(payload_byte_o),
    .byte_index_o  (byte_index_o),
    .last_o        (last_o)
  );

  // deframer shadow state
  logic [7:0]  sync_cfg = SYNC_RESET;
  logic [6:0]  rx_cnt   = '0;
  logic [15:0] len_fld  = '0;
  logic [15:0] run_sum  = '0;
  logic [7:0]  frame_buf [FRAME_BYTES];

  frame_res_t  step_res [$];
  frame_res_t  deframed_q [$];
  dir_row_t    dir_tab [DIR_ROWS];
  logic        calm_phase = 1'b0;
  int          errors = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void restart_hunt();
    rx_cnt  = '0;
    len_fld = '0;
    run_sum = '0;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    frame_res_t r;
    logic [15:0] chk;
    int n;
    int i;
    step_res.delete();
    if (rx_cnt == 0 && b != sync_cfg) return;
    if (rx_cnt >= FRAME_BYTES) begin
      restart_hunt();
      return;
    end
    frame_buf[rx_cnt] = b;
    rx_cnt++;
    if (rx_cnt <= HDR_BYTES + len_fld) run_sum += b;
    r       = '0;
    r.sword = {frame_buf[SW_HI_POS], frame_buf[SW_LO_POS]};
    r.last  = 1'b1;
    if (rx_cnt == HDR_BYTES) begin
      len_fld = {frame_buf[LEN_HI_POS], frame_buf[LEN_LO_POS]};
      if (len_fld > FRAME_BYTES - HDR_BYTES - CHK_BYTES) begin
        r.fstat = FS_TOO_LONG;
        step_res.push_back(r);
        restart_hunt();
        return;
      end
    end
    if (rx_cnt >= HDR_BYTES && rx_cnt == HDR_BYTES + len_fld + CHK_BYTES) begin
      n      = len_fld;
      chk    = {frame_buf[HDR_BYTES + n], frame_buf[HDR_BYTES + n + 1]};
      r.plen = 6'(n);
      if (chk != ~run_sum) begin
        r.fstat = FS_CHK_ERR;
        step_res.push_back(r);
      end else if (n == 0) begin
        r.fstat = FS_GOOD;
        step_res.push_back(r);
      end else begin
        for (i = 0; i < n; i++) begin
          r.fstat = FS_GOOD;
          r.has   = 1'b1;
          r.pbyte = frame_buf[HDR_BYTES + i];
          r.bidx  = 6'(i);
          r.last  = (i + 1 == n);
          step_res.push_back(r);
        end
      end
      restart_hunt();
    end
  endtask

  // one request on the byte channel; typed rows replace the predicted results
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_res_t typed_res);
    int gap;
    gap = calm_phase ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    if (typed) deframed_q.push_back(typed_res);
    else foreach (step_res[i]) deframed_q.push_back(step_res[i]);
  endtask

  task automatic send_frame(input frame_kind_e kind, output int nbytes);
    logic [7:0] fb [$];
    logic [15:0] len;
    logic [15:0] sum;
    int i;
    if (kind == FK_TOO_LONG) len = 16'($urandom_range(FRAME_BYTES - HDR_BYTES - CHK_BYTES + 1,
                                                      65535));
    else if ($urandom_range(0, 7) == 0) len = 16'($urandom_range(0, 54));
    else len = 16'($urandom_range(0, 6));
    fb.push_back(sync_cfg);
    repeat (5) fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    if (kind != FK_TOO_LONG) begin
      repeat (len) fb.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      foreach (fb[j]) sum += fb[j];
      sum = ~sum;
      if (kind == FK_BAD_CHK) sum ^= 16'($urandom_range(1, 65535));
      fb.push_back(sum[15:8]);
      fb.push_back(sum[7:0]);
    end
    nbytes = (kind == FK_CUT) ? $urandom_range(1, fb.size() - 1) : fb.size();
    for (i = 0; i < nbytes; i++) send_byte(fb[i], 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(posedge clk_i);
    sync_byte_we_i <= 1'b1;
    sync_byte_i    <= v;
    @(posedge clk_i);
    sync_cfg = v;
    sync_byte_we_i <= 1'b0;
  endtask

  function automatic dir_row_t mk_row(logic [7:0] b, logic typed, frame_status_e st,
                                      logic [15:0] sw);
    dir_row_t d;
    d.b     = b;
    d.typed = typed;
    d.fstat = st;
    d.sword = sw;
    return d;
  endfunction

  function automatic string fmt_res(frame_res_t r);
    return $sformatf("st=%0d sw=%h len=%0d has=%b byte=%h idx=%0d last=%b",
                     r.fstat, r.sword, r.plen, r.has, r.pbyte, r.bidx, r.last);
  endfunction

  // result side: random stall per request, compare against oldest expectation
  initial begin
    frame_res_t got;
    frame_res_t want;
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.fstat = frame_status_e'(frame_status_o);
        got.sword = status_word_o;
        got.plen  = payload_len_o;
        got.has   = has_byte_o;
        got.pbyte = payload_byte_o;
        got.bidx  = byte_index_o;
        got.last  = last_o;
        if (deframed_q.size() == 0) begin
          if (errors < 10) $display("unexpected result: %s", fmt_res(got));
          errors++;
        end else begin
          want = deframed_q.pop_front();
          if (got !== want) begin
            if (errors < 10) $display("mismatch: want %s / got %s", fmt_res(want), fmt_res(got));
            errors++;
          end
        end
        stall_left = calm_phase ? 0 : $urandom_range(0, 15);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    frame_res_t  r;
    logic [7:0]  phase_sync [4];
    int          ph;
    int          sent;
    int          n;
    int          pick;
    rst_ni         = 1'b0;
    sync_byte_we_i = 1'b0;
    sync_byte_i    = SYNC_RESET;
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;

    // noise, too-long header, checksum error, good one-byte frame
    dir_tab[0]  = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[1]  = mk_row(SYNC_RESET, 1'b0, FS_GOOD,     16'h0000);
    dir_tab[2]  = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[3]  = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[4]  = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[5]  = mk_row(8'h12,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[6]  = mk_row(8'h34,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[7]  = mk_row(8'hFF,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[8]  = mk_row(8'hFF,      1'b1, FS_TOO_LONG, 16'h1234);
    dir_tab[9]  = mk_row(SYNC_RESET, 1'b0, FS_GOOD,     16'h0000);
    dir_tab[10] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[11] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[12] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[13] = mk_row(8'hFF,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[14] = mk_row(8'hFF,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[15] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[16] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[17] = mk_row(8'hFF,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[18] = mk_row(8'hFF,      1'b1, FS_CHK_ERR,  16'hFFFF);
    dir_tab[19] = mk_row(SYNC_RESET, 1'b0, FS_GOOD,     16'h0000);
    dir_tab[20] = mk_row(8'h01,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[21] = mk_row(8'h02,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[22] = mk_row(8'h03,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[23] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[24] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[25] = mk_row(8'h00,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[26] = mk_row(8'h01,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[27] = mk_row(8'hFF,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[28] = mk_row(8'hFE,      1'b0, FS_GOOD,     16'h0000);
    dir_tab[29] = mk_row(8'h47,      1'b0, FS_GOOD,     16'h0000);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      r       = '0;
      r.fstat = dir_tab[i].fstat;
      r.sword = dir_tab[i].sword;
      r.last  = 1'b1;
      send_byte(dir_tab[i].b, dir_tab[i].typed, r);
    end
    in_valid_i <= 1'b0;

    phase_sync[0] = 8'h00;
    phase_sync[1] = 8'hFF;
    phase_sync[2] = 8'($urandom_range(0, 255));
    phase_sync[3] = SYNC_RESET;
    for (ph = 0; ph < 4; ph++) begin
      wait_drained();
      write_sync(phase_sync[ph]);
      calm_phase = (ph == 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          n = $urandom_range(1, 4);
          repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick < 5) begin
          send_frame(FK_BAD_CHK, n);
        end else if (pick < 6) begin
          send_frame(FK_TOO_LONG, n);
        end else if (pick < 7) begin
          send_frame(FK_CUT, n);
        end else begin
          send_frame(FK_GOOD, n);
        end
        sent += n;
      end
      in_valid_i <= 1'b0;
    end
    calm_phase = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    errors += deframed_q.size();
    if (errors == 0) begin
      $display("reader_frame_deframer_unit_tb: done, clean");
    end else begin
      $display("reader_frame_deframer_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("reader_frame_deframer_unit_tb: done, errors");
    $finish;
  end

endmodule
